/* hdl/burning_ship_escape_time_core_defines.svh */
// assertion macros for the burning ship escape-time core
// included by modules that carry concurrent checks; no other dependencies
`ifndef BURNING_SHIP_ESCAPE_TIME_CORE_DEFINES_SVH
`define BURNING_SHIP_ESCAPE_TIME_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// property holds at every rising clock edge outside reset
`define BSET_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define BSET_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSET_ASSERT(lbl, clk, rstn, prop, msg)
`define BSET_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hdl/bset_pkg.sv */
// shared types and constants for the burning ship escape-time core
// no dependencies; used by every stage module and the top level
package bset_pkg;

    localparam int unsigned FRAC_BITS = 28;
    localparam int unsigned CNT_W     = 11;
    localparam int unsigned TAG_W     = 2;

    localparam logic [CNT_W-1:0] ITER_CAP       = 11'd1024;
    localparam logic [CNT_W-1:0] MAX_ITER_RESET = 11'd256;
    // 2.0 in Q.28 and 4.0 in Q.56
    localparam logic [31:0]      TWO_Q28        = 32'h2000_0000;
    localparam logic [60:0]      FOUR_Q56       = 61'h0400_0000_0000_0000;

    // one pixel circulating in the iteration ring
    typedef struct packed {
        logic              valid;
        logic              done;
        logic [TAG_W-1:0]  tag;
        logic [31:0]       cr;     // signed Q4.28
        logic [31:0]       ci;     // signed Q4.28
        logic [31:0]       zr;     // magnitude, Q.28, always non-negative
        logic [32:0]       zi;     // signed Q.28
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  limit;
    } t_slot;

    // after magnitude stage
    typedef struct packed {
        t_slot       s;
        logic [29:0] ar;
        logic [29:0] ai;
    } t_mag;

    // after multiply stage, products in Q.56
    typedef struct packed {
        t_slot       s;
        logic [59:0] sr;
        logic [59:0] si;
        logic [59:0] pr;
    } t_mul;

    // after escape stage, terms back in Q.28
    typedef struct packed {
        t_slot       s;
        logic [32:0] dq;       // signed, floor((sr - si) / 2^28)
        logic [32:0] pq;       // unsigned, (2 * ar * ai) >> 28
    } t_esc;

endpackage

/* hdl/bset_mag_stage.sv */
// ring stage 1: limit check, part magnitudes and early escape on large parts
// depends on bset_pkg
module bset_mag_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bset_pkg::t_slot i_slot,
    output bset_pkg::t_mag  o_mag
);

    bset_pkg::t_mag r_mag;
    bset_pkg::t_mag n_mag;
    logic [32:0]    ai_full;
    logic           big;
    logic           exhausted;

    // magnitudes and stop conditions
    always_comb begin
        ai_full   = i_slot.zi[32] ? 33'(-i_slot.zi) : i_slot.zi;
        big       = (i_slot.zr > bset_pkg::TWO_Q28) || (ai_full > {1'b0, bset_pkg::TWO_Q28});
        exhausted = (i_slot.count >= i_slot.limit);
        n_mag     = '{s: i_slot, ar: i_slot.zr[29:0], ai: ai_full[29:0]};
        if (i_slot.valid && !i_slot.done && (exhausted || big)) begin
            n_mag.s.done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag.s.valid <= 1'b0;
        end else begin
            r_mag <= n_mag;
        end
    end

    assign o_mag = r_mag;

endmodule

/* hdl/bset_mul_stage.sv */
// ring stage 2: the two squares and the cross product
// depends on bset_pkg
module bset_mul_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bset_pkg::t_mag i_mag,
    output bset_pkg::t_mul o_mul
);

    bset_pkg::t_mul r_mul;
    bset_pkg::t_mul n_mul;
    logic [59:0]    sr;
    logic [59:0]    si;
    logic [59:0]    pr;

    // three 30x30 multipliers side by side
    assign sr = i_mag.ar * i_mag.ar;
    assign si = i_mag.ai * i_mag.ai;
    assign pr = i_mag.ar * i_mag.ai;

    always_comb begin
        n_mul = '{s: i_mag.s, sr: sr, si: si, pr: pr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul.s.valid <= 1'b0;
        end else begin
            r_mul <= n_mul;
        end
    end

    assign o_mul = r_mul;

endmodule

/* hdl/bset_esc_stage.sv */
// ring stage 3: |z|^2 escape test and scaling of the new terms to Q.28
// depends on bset_pkg
module bset_esc_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bset_pkg::t_mul i_mul,
    output bset_pkg::t_esc o_esc
);

    bset_pkg::t_esc     r_esc;
    bset_pkg::t_esc     n_esc;
    logic [60:0]        mag_sq;
    logic signed [60:0] diff;

    // escape compare and floor of the difference of squares
    always_comb begin
        mag_sq = {1'b0, i_mul.sr} + {1'b0, i_mul.si};
        diff   = $signed({1'b0, i_mul.sr}) - $signed({1'b0, i_mul.si});
        n_esc  = '{s: i_mul.s, dq: diff[60:28], pq: i_mul.pr[59:27]};
        if (i_mul.s.valid && !i_mul.s.done && (mag_sq > bset_pkg::FOUR_Q56)) begin
            n_esc.s.done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc.s.valid <= 1'b0;
        end else begin
            r_esc <= n_esc;
        end
    end

    assign o_esc = r_esc;

endmodule

/* hdl/burning_ship_escape_time_core.sv */
// Burning Ship escape-time core: takes a pixel coordinate c (signed Q4.28, imaginary
// part pre-negated) and returns how many iterations of z' = (|zr^2-zi^2+cr|,
// |2*zr*zi|+ci) ran before |z|^2 exceeded 4.0 or the limit min(configured limit, 1024)
// was reached. Pixels travel around a four-register ring (magnitude, multiply, escape,
// update), and up to four pixels iterate together, so a new pixel can enter before
// earlier ones finish; a result passes through the output register before o_out_valid.
// Results leave in input order: a finished pixel keeps circulating until it is the
// oldest one. The output register decouples the ring from a stalled consumer. The
// iteration limit resets to 256; the user must write it only while no transaction is
// in flight, and the block itself does not enforce this.
// depends on bset_pkg, the three stage modules and the defines header
`include "burning_ship_escape_time_core_defines.svh"

module burning_ship_escape_time_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_c_real,
    input  logic [31:0] i_c_imag,
    // iteration count output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [10:0] o_iteration_count,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_iter_limit
);

    logic [bset_pkg::CNT_W-1:0] r_max_iter;
    logic [bset_pkg::TAG_W-1:0] r_iss_tag;
    logic [bset_pkg::TAG_W-1:0] r_ret_tag;
    logic                       r_out_valid;
    logic [bset_pkg::CNT_W-1:0] r_out_count;
    bset_pkg::t_slot            r_head;
    bset_pkg::t_slot            n_head;

    bset_pkg::t_mag             mag;
    bset_pkg::t_mul             mul;
    bset_pkg::t_esc             esc;
    bset_pkg::t_slot            wb;
    logic signed [33:0]         zr_sum;
    logic signed [33:0]         zi_sum;
    logic [bset_pkg::CNT_W-1:0] limit_sat;
    logic                       out_free;
    logic                       eject;
    logic                       slot_free;
    logic                       in_acc;

    // iteration ring
    bset_mag_stage u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (r_head),
        .o_mag   (mag)
    );

    bset_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mag   (mag),
        .o_mul   (mul)
    );

    bset_esc_stage u_esc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mul   (mul),
        .o_esc   (esc)
    );

    // update z and count for pixels still iterating
    always_comb begin
        zr_sum = $signed({esc.dq[32], esc.dq}) + $signed({{2{esc.s.cr[31]}}, esc.s.cr});
        zi_sum = $signed({1'b0, esc.pq}) + $signed({{2{esc.s.ci[31]}}, esc.s.ci});
        wb     = esc.s;
        if (esc.s.valid && !esc.s.done) begin
            wb.zr    = zr_sum[33] ? 32'(-zr_sum) : zr_sum[31:0];
            wb.zi    = zi_sum[32:0];
            wb.count = esc.s.count + 1'b1;
        end
    end

    // retire the oldest finished pixel, then admit a new one into a free slot
    assign limit_sat  = (r_max_iter > bset_pkg::ITER_CAP) ? bset_pkg::ITER_CAP : r_max_iter;
    assign out_free   = !r_out_valid || i_out_ready;
    assign eject      = wb.valid && wb.done && (wb.tag == r_ret_tag) && out_free;
    assign slot_free  = !wb.valid || eject;
    assign o_in_ready = slot_free;
    assign in_acc     = i_in_valid && slot_free;

    always_comb begin
        n_head = wb;
        if (eject) begin
            n_head.valid = 1'b0;
        end
        if (in_acc) begin
            n_head = '{valid: 1'b1, done: 1'b0, tag: r_iss_tag, cr: i_c_real,
                       ci: i_c_imag, zr: '0, zi: '0, count: '0, limit: limit_sat};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else begin
            r_head <= n_head;
        end
    end

    // tags keep results in input order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_tag <= '0;
            r_ret_tag <= '0;
        end else begin
            if (in_acc) begin
                r_iss_tag <= r_iss_tag + 1'b1;
            end
            if (eject) begin
                r_ret_tag <= r_ret_tag + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eject) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eject) begin
            r_out_count <= wb.count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= bset_pkg::MAX_ITER_RESET;
        end else if (i_cfg_valid) begin
            r_max_iter <= i_iter_limit;
        end
    end

    // checks
    `BSET_ASSERT(a_count_in_limit, i_clk, i_rst_n, !wb.valid || (wb.count <= wb.limit), "count passed its limit")
    `BSET_ASSERT(a_out_capped, i_clk, i_rst_n, !r_out_valid || (r_out_count <= bset_pkg::ITER_CAP), "count above cap")
    `BSET_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, in_acc, r_head.valid && !r_head.done, "accepted pixel not in ring")
    `BSET_ASSERT_NEXT(a_eject_shows, i_clk, i_rst_n, eject, r_out_valid, "retired pixel not presented")

endmodule

/* dv/bset_escape_checker.sv */
`timescale 1ns / 100ps
// scoreboard for the burning ship escape-time core: predicts the iteration count
// of each accepted pixel and compares it with the next count out; depends on bset_pkg
module bset_escape_checker
    import bset_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [31:0]      i_c_real,
    input  logic [31:0]      i_c_imag,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [CNT_W-1:0] i_iteration_count,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CNT_W-1:0] i_iter_limit,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_checked,
    output int               o_at_limit,
    output int               o_cfg_writes
);

    localparam longint unsigned TWO_Q28_W  = 64'h0000_0000_2000_0000;
    localparam longint unsigned FOUR_Q56_W = 64'h0400_0000_0000_0000;

    typedef struct packed {
        logic [31:0]      re;
        logic [31:0]      im;
        logic [CNT_W-1:0] count;
        logic             at_limit;
    } t_pixel_count;

    t_pixel_count     pixel_counts[$];
    logic [CNT_W-1:0] iter_limit;

    // clamp the configured limit to the hardware cap
    function automatic int unsigned clamped_limit(input logic [CNT_W-1:0] max_it);
        return (max_it > ITER_CAP) ? int'(ITER_CAP) : int'(max_it);
    endfunction

    // escape-time iteration in Q.28 with wide intermediates
    function automatic logic [CNT_W-1:0] escape_count(input logic [31:0] re,
                                                      input logic [31:0] im,
                                                      input int unsigned limit);
        longint           cr, ci, zr, zi, diff, dq;
        longint unsigned  ar, ai, sr, si, prod;
        int unsigned      n;
        cr = $signed(re);
        ci = $signed(im);
        zr = 0;
        zi = 0;
        n  = 0;
        while (n < limit) begin
            ar = (zr < 0) ? -zr : zr;
            ai = (zi < 0) ? -zi : zi;
            // a part above 2.0 escapes on its own
            if (ar > TWO_Q28_W || ai > TWO_Q28_W)
                break;
            sr = ar * ar;
            si = ai * ai;
            if (sr + si > FOUR_Q56_W)
                break;
            // floor of the difference back to Q.28
            diff = longint'(sr) - longint'(si);
            dq   = diff >>> FRAC_BITS;
            prod = (ar * ai) << 1;
            zi   = longint'(prod >> FRAC_BITS) + ci;
            zr   = dq + cr;
            if (zr < 0)
                zr = -zr;
            n++;
        end
        return CNT_W'(n);
    endfunction

    // watch all three channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_pixel_count pix;
        t_pixel_count head;
        int unsigned  lim;
        if (!i_rst_n) begin
            iter_limit = MAX_ITER_RESET;
            pixel_counts.delete();
        end else begin
            // register write transaction
            if (i_cfg_valid && i_cfg_ready) begin
                iter_limit = i_iter_limit;
                o_cfg_writes++;
            end
            // pixel transaction: predict its count
            if (i_in_valid && i_in_ready) begin
                lim          = clamped_limit(iter_limit);
                pix.re       = i_c_real;
                pix.im       = i_c_imag;
                pix.count    = escape_count(i_c_real, i_c_imag, lim);
                pix.at_limit = (lim != 0) && (int'(pix.count) == lim);
                pixel_counts.push_back(pix);
            end
            // count transaction: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (pixel_counts.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected count %0d with no pixel outstanding",
                                 i_iteration_count);
                end else begin
                    head = pixel_counts.pop_front();
                    o_checked++;
                    if (head.at_limit)
                        o_at_limit++;
                    if (i_iteration_count !== head.count) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("count mismatch for c=(%h,%h): expected %0d, got %0d",
                                     head.re, head.im, head.count, i_iteration_count);
                    end
                end
            end
        end
        o_pending = pixel_counts.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// top of the escape-time core bench: clock, reset, pixel and limit stimulus, verdict
// depends on bset_pkg, burning_ship_escape_time_core and bset_escape_checker
module tb;
    import bset_pkg::*;

    localparam int          IDLE_LIMIT = 20000;
    localparam logic [31:0] MAX_POS    = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_NEG    = 32'h8000_0000;
    localparam logic [31:0] TWO_POS    = TWO_Q28;
    localparam logic [31:0] TWO_NEG    = 32'hE000_0000;
    localparam logic [31:0] ONE_LSB    = 32'h0000_0001;
    localparam logic [31:0] MINUS_LSB  = 32'hFFFF_FFFF;
    localparam int          N_PHASES   = 10;

    logic             i_clk            = 1'b0;
    logic             i_rst_n          = 1'b0;
    logic             i_in_valid       = 1'b0;
    logic [31:0]      i_c_real         = '0;
    logic [31:0]      i_c_imag         = '0;
    logic             i_out_ready      = 1'b0;
    logic             i_cfg_valid      = 1'b0;
    logic [CNT_W-1:0] i_iter_limit     = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [CNT_W-1:0] o_iteration_count;
    logic             o_cfg_ready;

    int mismatches;
    int pending;
    int checked;
    int at_limit;
    int cfg_writes;
    int idle_cycles = 0;
    bit quiet_in    = 1'b0;
    bit quiet_out   = 1'b0;

    always #2 i_clk = ~i_clk;

    burning_ship_escape_time_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_c_real          (i_c_real),
        .i_c_imag          (i_c_imag),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_iteration_count (o_iteration_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_iter_limit      (i_iter_limit)
    );

    bset_escape_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_c_real          (i_c_real),
        .i_c_imag          (i_c_imag),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_iteration_count (o_iteration_count),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_iter_limit      (i_iter_limit),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_at_limit        (at_limit),
        .o_cfg_writes      (cfg_writes)
    );

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // count consumer with random stalls and stall-free stretches
    initial begin : count_sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 19) == 0)
                quiet_out = !quiet_out;
            stall = quiet_out ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // one pixel transaction, entered and left at a falling edge
    task automatic send_pixel(input logic [31:0] re, input logic [31:0] im);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_c_real   <= re;
        i_c_imag   <= im;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every predicted count to come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // limit register write, only with the core empty
    task automatic write_limit(input logic [CNT_W-1:0] value);
        i_cfg_valid  <= 1'b1;
        i_iter_limit <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // coordinates: full range, the region around the ship, and near the origin
    task automatic pick_point(output logic [31:0] re, output logic [31:0] im);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            re = $urandom;
            im = $urandom;
        end else if (sel < 8) begin
            re = $urandom_range(0, 32'h4000_0000) - 32'h2800_0000;
            im = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        end else begin
            re = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            im = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        end
    endtask

    initial begin : stimulus
        logic [31:0]      re;
        logic [31:0]      im;
        logic [CNT_W-1:0] phase_limit [N_PHASES];
        int               phase_items [N_PHASES];
        phase_limit = '{11'd16, 11'd0, 11'd1, 11'd64, 11'd5, 11'd100, 11'd2047,
                        11'd256, 11'd1024, 11'd2};
        phase_items = '{120, 30, 40, 120, 60, 100, 25, 90, 40, 60};
        phase_limit[N_PHASES-1] = CNT_W'($urandom_range(2, 300));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limit: origin, field extremes, the 2.0 boundaries, one-lsb floor cases
        send_pixel('0, '0);
        send_pixel(MAX_POS, MAX_POS);
        send_pixel(MIN_NEG, MIN_NEG);
        send_pixel(MIN_NEG, MAX_POS);
        send_pixel(MAX_POS, MIN_NEG);
        send_pixel(TWO_POS, '0);
        send_pixel(TWO_NEG, '0);
        send_pixel('0, TWO_POS);
        send_pixel('0, TWO_NEG);
        send_pixel(ONE_LSB, ONE_LSB);
        send_pixel(MINUS_LSB, MINUS_LSB);
        send_pixel(32'hE400_0000, '0);
        drain();

        // zero limit gives a count of zero
        write_limit(11'd0);
        send_pixel('0, '0);
        send_pixel(MAX_POS, MIN_NEG);
        drain();

        // single iteration
        write_limit(11'd1);
        send_pixel('0, '0);
        send_pixel(TWO_POS, '0);
        send_pixel(MIN_NEG, MIN_NEG);
        drain();

        // limit above the cap saturates
        write_limit(11'd2047);
        send_pixel('0, '0);
        send_pixel(TWO_NEG, '0);
        drain();

        write_limit(11'd1024);
        send_pixel('0, '0);
        send_pixel(MINUS_LSB, ONE_LSB);
        drain();

        // random phases, one limit each
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_limit(phase_limit[ph]);
            for (int k = 0; k < phase_items[ph]; k++) begin
                if ($urandom_range(0, 15) == 0)
                    quiet_in = !quiet_in;
                // hold off mid-phase until the core is empty
                if (ph % 3 == 0 && k == phase_items[ph] / 2)
                    drain();
                pick_point(re, im);
                send_pixel(re, im);
            end
            drain();
        end

        repeat (20) @(negedge i_clk);
        $display("covered %0d pixels under %0d limit writes, %0d of them ran to the limit",
                 checked, cfg_writes, at_limit);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* burning_ship_escape_time_core.f */
+incdir+hdl
hdl/bset_pkg.sv
hdl/bset_mag_stage.sv
hdl/bset_mul_stage.sv
hdl/bset_esc_stage.sv
hdl/burning_ship_escape_time_core.sv
dv/bset_escape_checker.sv
dv/tb.sv
